// ===== hw/rtl/rmcg_pkg.sv =====
// ----------------------------------------------------------------------------
// rmcg_pkg
// Shared types and constants of the rgb max-channel gradient magnitude block.
// ----------------------------------------------------------------------------
package rmcg_pkg;

   // sample and pixel geometry
   localparam int SAMPLE_W = 16;
   localparam int CHANNELS = 3;
   localparam int PIXEL_W  = SAMPLE_W * CHANNELS;
   localparam int GRAD_W   = SAMPLE_W + 1;

   // configuration registers
   localparam int FRAME_WIDTH_W  = 13;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam int MIN_DIM          = 3;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // line store depth default
   localparam int MAX_LINE_WIDTH_DEF = 4096;

   // queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   // one line store column: two rows of the same column
   typedef struct packed {
      logic [PIXEL_W-1:0] older;
      logic [PIXEL_W-1:0] newer;
   } line_entry_type;

   // per-channel l1 sums of one interior pixel
   typedef struct packed {
      logic                           frame_last;
      logic [CHANNELS-1:0][GRAD_W-1:0] sum;
   } grad_sums_type;

endpackage

// ===== hw/rtl/rmcg_ram.sv =====
// ----------------------------------------------------------------------------
// rmcg_ram
// Generic simple dual-port ram, one write and one registered read per cycle,
// with write-through on a same-address collision.
// ----------------------------------------------------------------------------
module rmcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, new data wins on collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rmcg_front.sv =====
// ----------------------------------------------------------------------------
// rmcg_front
// Accepts pixels, keeps the column and row counters and the line store,
// classifies interior pixels and forms the per-channel l1 sums.
// ----------------------------------------------------------------------------
module rmcg_front import rmcg_pkg::*; #(
   parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [SAMPLE_W-1:0]      req_red,
   input  logic [SAMPLE_W-1:0]      req_green,
   input  logic [SAMPLE_W-1:0]      req_blue,
   input  logic [QUEUE_LEVEL_W-1:0] q_level,
   output logic                     q_push,
   output grad_sums_type            q_wdata
);

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int CMP_W = ((COL_W > FRAME_WIDTH_W) ? COL_W : FRAME_WIDTH_W) + 1;
   localparam int HGT_W = FRAME_HEIGHT_W + 1;
   localparam int OCC_W = QUEUE_LEVEL_W + 1;

   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // configuration registers
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   // counters and recent pixels of the current row
   logic [COL_W-1:0]          col_ff, col_in;
   logic [FRAME_HEIGHT_W-1:0] row_ff, row_in;
   logic [PIXEL_W-1:0]        rec0_ff, rec1_ff;

   // stage 1
   logic                      s1_val_ff, s1_res_ff, s1_shift_ff, s1_lastcol_ff;
   logic                      s1_flast_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic [PIXEL_W-1:0]        s1_down_ff, s1_rec1_ff, s1_cur_ff;
   line_entry_type            win1_ff, win2_ff;

   // deferred row-end writes
   logic                      dp1_ff, dp1_in, dp2_ff, dp2_in;
   logic [COL_W-1:0]          dp1_addr_ff, dp2_addr_ff;
   line_entry_type            dp1_data_ff, dp2_data_ff;

   // stage 2
   logic                      s2_val_ff, s2_flast_ff;
   logic [SAMPLE_W-1:0]       dx_ff [CHANNELS];
   logic [SAMPLE_W-1:0]       dy_ff [CHANNELS];
   logic [SAMPLE_W-1:0]       dx_in [CHANNELS];
   logic [SAMPLE_W-1:0]       dy_in [CHANNELS];

   logic                      accept;
   logic [CMP_W-1:0]          width_raw, width_use;
   logic [HGT_W-1:0]          height_raw, height_use;
   logic                      last_col, last_row, has_res, col_ge2;
   logic [PIXEL_W-1:0]        cur;
   logic [OCC_W-1:0]          occupancy;

   logic                      wr_en;
   logic [COL_W-1:0]          wr_addr;
   line_entry_type            wr_data;
   line_entry_type            rd_data;
   logic                      s1_wr;

   // credit check against the queue and the beats in flight
   assign occupancy = OCC_W'(q_level) + OCC_W'(s1_val_ff & s1_res_ff) + OCC_W'(s2_val_ff);
   assign req_full  = (occupancy >= OCC_W'(QUEUE_DEPTH));
   assign accept    = req_push & ~req_full;
   assign cur       = {req_red, req_green, req_blue};

   // clamped frame geometry
   always_comb begin
      width_raw = CMP_W'(frame_width_ff);
      if (width_raw < CMP_W'(MIN_DIM)) begin
         width_use = CMP_W'(MIN_DIM);
      end else if (width_raw > CMP_W'(MAX_LINE_WIDTH)) begin
         width_use = CMP_W'(MAX_LINE_WIDTH);
      end else begin
         width_use = width_raw;
      end
      height_raw = HGT_W'(frame_height_ff);
      height_use = (height_raw < HGT_W'(MIN_DIM)) ? HGT_W'(MIN_DIM) : height_raw;
   end

   // position classification
   assign last_col = ((CMP_W'(col_ff) + CMP_W'(1)) >= width_use);
   assign last_row = ((HGT_W'(row_ff) + HGT_W'(1)) >= height_use);
   assign col_ge2  = (col_ff >= COL_W'(2));
   assign has_res  = col_ge2 && (row_ff >= FRAME_HEIGHT_W'(2));

   // counter next state
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : (row_ff + FRAME_HEIGHT_W'(1));
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_W'(FRAME_WIDTH_RST);
         frame_height_ff <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
         col_ff          <= '0;
         row_ff          <= '0;
         s1_val_ff       <= 1'b0;
         s1_res_ff       <= 1'b0;
         s2_val_ff       <= 1'b0;
         dp1_ff          <= 1'b0;
         dp2_ff          <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_wdata[FRAME_WIDTH_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_val_ff <= accept;
         s1_res_ff <= accept & has_res;
         s2_val_ff <= s1_val_ff & s1_res_ff;
         dp1_ff    <= dp1_in;
         dp2_ff    <= dp2_in;
      end
   end

   // stage 1 payload and recent pixels
   always_ff @(posedge clock) begin
      if (accept) begin
         rec0_ff       <= cur;
         rec1_ff       <= rec0_ff;
         s1_shift_ff   <= col_ge2;
         s1_lastcol_ff <= last_col;
         s1_flast_ff   <= last_col & last_row;
         s1_col_ff     <= col_ff;
         s1_down_ff    <= rec0_ff;
         s1_rec1_ff    <= rec1_ff;
         s1_cur_ff     <= cur;
      end
   end

   // line store: one entry holds two rows of a column
   rmcg_ram #(
      .WIDTH ($bits(line_entry_type)),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   // store update, lagging two columns; row end columns follow when the port is free
   assign s1_wr = s1_val_ff & s1_shift_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (s1_wr) begin
         wr_en         = 1'b1;
         wr_addr       = s1_col_ff - COL_W'(2);
         wr_data.older = win2_ff.newer;
         wr_data.newer = s1_rec1_ff;
      end else if (dp1_ff) begin
         wr_en   = 1'b1;
         wr_addr = dp1_addr_ff;
         wr_data = dp1_data_ff;
      end else if (dp2_ff) begin
         wr_en   = 1'b1;
         wr_addr = dp2_addr_ff;
         wr_data = dp2_data_ff;
      end
   end

   always_comb begin
      dp1_in = dp1_ff & s1_wr;
      dp2_in = dp2_ff & (s1_wr | dp1_ff);
      if (s1_val_ff && s1_lastcol_ff) begin
         dp1_in = 1'b1;
         dp2_in = 1'b1;
      end
   end

   // window of the two previous columns and the deferred write data
   always_ff @(posedge clock) begin
      if (s1_val_ff) begin
         win1_ff <= rd_data;
         win2_ff <= win1_ff;
      end
      if (s1_val_ff && s1_lastcol_ff) begin
         dp1_addr_ff       <= s1_col_ff - COL_W'(1);
         dp1_data_ff.older <= win1_ff.newer;
         dp1_data_ff.newer <= s1_down_ff;
         dp2_addr_ff       <= s1_col_ff;
         dp2_data_ff.older <= rd_data.newer;
         dp2_data_ff.newer <= s1_cur_ff;
      end
   end

   // central differences per channel
   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         dx_in[k] = abs_diff(rd_data.newer[k*SAMPLE_W +: SAMPLE_W],
                             win2_ff.newer[k*SAMPLE_W +: SAMPLE_W]);
         dy_in[k] = abs_diff(s1_down_ff[k*SAMPLE_W +: SAMPLE_W],
                             win1_ff.older[k*SAMPLE_W +: SAMPLE_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_val_ff && s1_res_ff) begin
         s2_flast_ff <= s1_flast_ff;
         for (int k = 0; k < CHANNELS; k++) begin
            dx_ff[k] <= dx_in[k];
            dy_ff[k] <= dy_in[k];
         end
      end
   end

   // l1 sums into the queue
   always_comb begin
      q_wdata.frame_last = s2_flast_ff;
      for (int k = 0; k < CHANNELS; k++) begin
         q_wdata.sum[k] = GRAD_W'(dx_ff[k]) + GRAD_W'(dy_ff[k]);
      end
   end

   assign q_push = s2_val_ff;

endmodule

// ===== hw/rtl/rmcg_queue.sv =====
// ----------------------------------------------------------------------------
// rmcg_queue
// Short register queue of per-channel sums between front and back.
// ----------------------------------------------------------------------------
module rmcg_queue import rmcg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  grad_sums_type            wdata,
   input  logic                     pop,
   output grad_sums_type            rdata,
   output logic                     empty,
   output logic [QUEUE_LEVEL_W-1:0] level
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   grad_sums_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LEVEL_W-1:0]   level_ff, level_in;

   // pointers and fill level
   always_comb begin
      level_in = level_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + QUEUE_LEVEL_W'(1);
         2'b01:   level_in = level_ff - QUEUE_LEVEL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = slot_ff[rd_ptr_ff];
   assign empty = (level_ff == '0);
   assign level = level_ff;

endmodule

// ===== hw/rtl/rmcg_back.sv =====
// ----------------------------------------------------------------------------
// rmcg_back
// Takes per-channel sums from the queue, picks the largest channel and holds
// the result beat in the output register.
// ----------------------------------------------------------------------------
module rmcg_back import rmcg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  grad_sums_type     q_rdata,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [GRAD_W-1:0] rsp_grad_mag,
   output logic              rsp_frame_last
);

   logic              out_val_ff, out_val_in;
   logic [GRAD_W-1:0] grad_ff, grad_in;
   logic              flast_ff;
   logic [GRAD_W-1:0] max_rg;

   // load when the output register is free or being drained
   assign q_pop = ~q_empty & (~out_val_ff | rsp_pop);

   // largest of the three channels
   always_comb begin
      max_rg  = (q_rdata.sum[2] > q_rdata.sum[1]) ? q_rdata.sum[2] : q_rdata.sum[1];
      grad_in = (max_rg > q_rdata.sum[0]) ? max_rg : q_rdata.sum[0];
   end

   always_comb begin
      out_val_in = out_val_ff;
      if (q_pop) begin
         out_val_in = 1'b1;
      end else if (rsp_pop) begin
         out_val_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_val_ff <= 1'b0;
      end else begin
         out_val_ff <= out_val_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         grad_ff  <= grad_in;
         flast_ff <= q_rdata.frame_last;
      end
   end

   assign rsp_empty      = ~out_val_ff;
   assign rsp_grad_mag   = grad_ff;
   assign rsp_frame_last = flast_ff;

endmodule

// ===== hw/rtl/rgb_max_channel_gradient_magnitude.sv =====
// ----------------------------------------------------------------------------
// rgb_max_channel_gradient_magnitude
// Largest per-channel l1 central-difference gradient of an rgb pixel stream.
//
// Pixels enter in raster order on the req_ queue port (req_push / req_full);
// one beat is taken per cycle while req_full is low. Each interior pixel
// gives one result beat on the rsp_ port (rsp_empty / rsp_pop): grad_mag is
// max over red, green, blue of |dx|+|dy|; divide by 131070 for a 0..1 scale.
// frame_last marks the final interior pixel of a frame. Border pixels give
// no beat. The result of pixel (x,y) is formed when pixel (x+1,y+1) is taken
// and passes the difference register, the queue and the output register, the
// line store being read at the accepting edge itself. Throughput is one pixel
// per cycle while req_full is low; the line store is one ram with one read and
// one write port, and the two extra column writes of a row end are deferred
// until the write port is free. A stalled receiver fills the 4-entry queue,
// then req_full rises; nothing is dropped. Reset clears counters and queue and
// loads width 640, height 480; the line store is not cleared and needs no
// startup pass. csr_ writes (index 0 width, 1 height) are to be made by the
// user while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rgb_max_channel_gradient_magnitude import rmcg_pkg::*; #(
   parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SAMPLE_W-1:0]    req_red,
   input  logic [SAMPLE_W-1:0]    req_green,
   input  logic [SAMPLE_W-1:0]    req_blue,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [GRAD_W-1:0]      rsp_grad_mag,
   output logic                   rsp_frame_last
);

   logic                     q_push, q_pop, q_empty;
   grad_sums_type            q_wdata, q_rdata;
   logic [QUEUE_LEVEL_W-1:0] q_level;

   // front: counters, line store, differences
   rmcg_front #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_level   (q_level),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // decoupling queue
   rmcg_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .level (q_level)
   );

   // back: channel max and result register
   rmcg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_rdata        (q_rdata),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_grad_mag   (rsp_grad_mag),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rgb max-channel gradient magnitude block.
//
// Pixels go in through the req_ queue port, gradient beats are taken from the
// rsp_ port. A behavioral copy of the block (two line stores, counters and
// the last two pixels) predicts every beat when its pixel is accepted; each
// taken beat is checked against the oldest prediction. Stimulus is a few
// hand-made frames, then random frames of small sizes with register changes
// in mid-frame, then one frame at the widest width setting. Both ports idle
// at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmcg_pkg::*;

   localparam int LINE_DEPTH    = MAX_LINE_WIDTH_DEF;
   localparam int DRAIN_CYCLES  = 10;
   localparam int RANDOM_PIXELS = 1100;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } pixel_in_type;

   typedef struct {
      logic [GRAD_W-1:0] mag;
      logic              last;
   } grad_out_type;

   // block ports
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_we         = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;
   logic                   req_push       = 1'b0;
   logic                   req_full;
   logic [SAMPLE_W-1:0]    req_red        = '0;
   logic [SAMPLE_W-1:0]    req_green      = '0;
   logic [SAMPLE_W-1:0]    req_blue       = '0;
   logic                   rsp_empty;
   logic                   rsp_pop        = 1'b0;
   logic [GRAD_W-1:0]      rsp_grad_mag;
   logic                   rsp_frame_last;

   // pixels waiting to be sent and gradient beats waiting to be seen
   pixel_in_type pixel_q[$];
   grad_out_type grad_expect_q[$];

   // behavioral copy of the block state
   pixel_type                 older_line [LINE_DEPTH];
   pixel_type                 newer_line [LINE_DEPTH];
   int unsigned               pixel_col  = 0;
   int unsigned               pixel_row  = 0;
   pixel_type                 prev_px    = '0;
   pixel_type                 prev2_px   = '0;
   logic [FRAME_WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
   logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);

   // idling and bookkeeping
   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 61;
   int unsigned error_count   = 0;
   int unsigned pixels_in     = 0;
   int unsigned beats_out     = 0;
   int unsigned frame_ends    = 0;
   int unsigned reg_writes    = 0;

   rgb_max_channel_gradient_magnitude uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_grad_mag   (rsp_grad_mag),
      .rsp_frame_last (rsp_frame_last)
   );

   always #2 clock = ~clock;

   task automatic report_error(input string msg);
      error_count++;
      $display("mismatch at %0t ns: %s", $realtime, msg);
   endtask

   // widths in use after clamping
   function automatic int unsigned line_width();
      int unsigned w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
   endfunction

   function automatic int unsigned frame_rows();
      int unsigned h;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   function automatic int unsigned abs_step(input logic [SAMPLE_W-1:0] a,
                                            input logic [SAMPLE_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // store update of one column: newer moves down, the pixel goes in newer
   function automatic void retire_column(input int unsigned c, input pixel_type px);
      int unsigned i;
      i = c % LINE_DEPTH;
      older_line[i] = newer_line[i];
      newer_line[i] = px;
   endfunction

   // advance the state by one pixel, queue the gradient beat it completes
   function automatic void take_pixel(input logic [SAMPLE_W-1:0] r,
                                      input logic [SAMPLE_W-1:0] g,
                                      input logic [SAMPLE_W-1:0] b);
      pixel_type    cur, up_px, right_px, left_px;
      int unsigned  w, h, c, best, v;
      bit           last_col, last_row;
      grad_out_type beat;
      w        = line_width();
      h        = frame_rows();
      c        = pixel_col;
      cur      = {r, g, b};
      last_col = (c + 1 >= w);
      last_row = (pixel_row + 1 >= h);

      // interior pixel one row up and one column left of the new one
      if (c >= 2 && pixel_row >= 2) begin
         up_px    = older_line[(c - 1) % LINE_DEPTH];
         right_px = newer_line[c % LINE_DEPTH];
         left_px  = newer_line[(c - 2) % LINE_DEPTH];
         best     = 0;
         for (int k = 0; k < CHANNELS; k++) begin
            v = abs_step(right_px[SAMPLE_W*k +: SAMPLE_W], left_px[SAMPLE_W*k +: SAMPLE_W]) +
                abs_step(prev_px[SAMPLE_W*k +: SAMPLE_W], up_px[SAMPLE_W*k +: SAMPLE_W]);
            if (v > best) best = v;
         end
         beat.mag  = GRAD_W'(best);
         beat.last = last_col && last_row;
         grad_expect_q.push_back(beat);
      end

      // line stores trail the stream by two columns, flushed at row end
      if (c >= 2) retire_column(c - 2, prev2_px);
      if (last_col) begin
         retire_column(c - 1, prev_px);
         retire_column(c, cur);
      end
      prev2_px = prev_px;
      prev_px  = cur;

      if (last_col) begin
         pixel_col = 0;
         pixel_row = last_row ? 0 : ((pixel_row + 1) & 16'hFFFF);
      end else begin
         pixel_col = c + 1;
      end
   endfunction

   // pixels still needed to close the frame in progress
   function automatic int unsigned pixels_to_frame_end();
      int unsigned w, h, rest;
      w = line_width();
      h = frame_rows();
      if (pixel_col == 0 && pixel_row == 0) return 0;
      rest = (pixel_col + 1 >= w) ? 1 : w - pixel_col;
      if (pixel_row + 1 < h) rest += (h - pixel_row - 1) * w;
      return rest;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(0, 15));
         3:       return SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic queue_pixel(input logic [SAMPLE_W-1:0] r,
                              input logic [SAMPLE_W-1:0] g,
                              input logic [SAMPLE_W-1:0] b);
      pixel_in_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      pixel_q.push_back(px);
   endtask

   task automatic queue_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         queue_pixel(random_sample(), random_sample(), random_sample());
   endtask

   // wait for the block to go idle, then write width and height
   task automatic program_frame(input logic [CSR_DATA_W-1:0] w_val,
                                input logic [CSR_DATA_W-1:0] h_val);
      while (pixel_q.size() != 0 || req_push || grad_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w_val;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h_val;
      @(posedge clock);
      csr_we     <= 1'b0;
      width_reg  = w_val[FRAME_WIDTH_W-1:0];
      height_reg = h_val;
      reg_writes += 2;
   endtask

   // pixel driver: holds a beat while full, idles at random, noise when idle
   always @(posedge clock) begin : drive_pixels
      pixel_in_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            pixels_in++;
            take_pixel(req_red, req_green, req_blue);
         end
         if (!(req_push && req_full)) begin
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pixel_q.pop_front();
               req_push  <= 1'b1;
               req_red   <= nxt.red;
               req_green <= nxt.green;
               req_blue  <= nxt.blue;
            end else begin
               req_push  <= 1'b0;
               req_red   <= SAMPLE_W'($urandom);
               req_green <= SAMPLE_W'($urandom);
               req_blue  <= SAMPLE_W'($urandom);
            end
         end
      end
   end

   // result monitor: compare each taken beat with the oldest prediction
   always @(posedge clock) begin : watch_gradients
      grad_out_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         beats_out++;
         if (rsp_frame_last === 1'b1) frame_ends++;
         if (grad_expect_q.size() == 0) begin
            report_error($sformatf("gradient beat %0d with none expected", rsp_grad_mag));
         end else begin
            want = grad_expect_q.pop_front();
            if (rsp_grad_mag !== want.mag)
               report_error($sformatf("grad_mag %0d, expected %0d", rsp_grad_mag, want.mag));
            if (rsp_frame_last !== want.last)
               report_error($sformatf("frame_last %b, expected %b",
                                      rsp_frame_last, want.last));
         end
      end
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // stimulus
   initial begin : stimulus
      int unsigned random_sent, w_raw, h_raw, n;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // smallest frame via clamped registers, center pixel at full scale
      program_frame(16'd1, 16'd2);
      queue_pixel(16'h0000, 16'h0000, 16'h0000);
      queue_pixel(16'h0000, 16'hFFFF, 16'h1234);
      queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_pixel(16'h0000, 16'hFFFF, 16'h0000);
      queue_pixel(16'h8000, 16'h8000, 16'h8000);
      queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
      queue_pixel(16'hFFFF, 16'h0000, 16'h0000);
      queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
      queue_pixel(16'h0000, 16'h0000, 16'h0000);

      // 4x4 checkerboard and ramps
      program_frame(16'd4, 16'd4);
      for (int y = 0; y < 4; y++)
         for (int x = 0; x < 4; x++)
            queue_pixel(((x + y) % 2 != 0) ? 16'hFFFF : 16'h0000,
                        SAMPLE_W'(x * 16'h5555), SAMPLE_W'(y * 16'h4000 + x));

      // random frames, some with a register change mid-frame
      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_sent >= RANDOM_PIXELS / 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 36;
         end
         case ($urandom_range(0, 9))
            0:       w_raw = $urandom_range(0, 2);
            1:       w_raw = $urandom_range(13, 40);
            default: w_raw = $urandom_range(3, 12);
         endcase
         if ($urandom_range(0, 3) == 0) w_raw |= $urandom_range(1, 7) << FRAME_WIDTH_W;
         case ($urandom_range(0, 9))
            0:       h_raw = $urandom_range(0, 2);
            1:       h_raw = $urandom_range(7, 12);
            default: h_raw = $urandom_range(3, 6);
         endcase
         program_frame(CSR_DATA_W'(w_raw), CSR_DATA_W'(h_raw));
         n = $urandom_range(1, 2) * line_width() * frame_rows();
         queue_random(n);
         random_sent += n;

         // shrink width, change height while a frame is open, then close it
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, line_width() * frame_rows() - 1);
            queue_random(n);
            random_sent += n;
            w_raw = $urandom_range(0, line_width());
            if ($urandom_range(0, 3) == 0) w_raw |= $urandom_range(1, 7) << FRAME_WIDTH_W;
            program_frame(CSR_DATA_W'(w_raw), CSR_DATA_W'($urandom_range(0, frame_rows() + 4)));
            n = pixels_to_frame_end();
            queue_random(n);
            random_sent += n;
         end
      end

      // widest width setting (all width bits set, clamped) and tallest frame
      // register, then narrowed and shortened inside the first row
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_frame(16'hFFFF, 16'hFFFF);
      queue_random(LINE_DEPTH / 8);
      program_frame(16'd5, 16'd4);
      queue_random(pixels_to_frame_end());

      // drain
      while (pixel_q.size() != 0 || req_push) @(posedge clock);
      for (int i = 0; i < 2000 && grad_expect_q.size() != 0; i++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grad_expect_q.size() != 0)
         report_error($sformatf("%0d gradient beats never arrived", grad_expect_q.size()));

      $display("covered %0d pixels and %0d gradient beats, %0d of them frame ends,",
               pixels_in, beats_out, frame_ends);
      $display("with %0d register writes and the width setting clamped up to %0d",
               reg_writes, LINE_DEPTH);
      if (error_count == 0)
         $display("[rgb_max_channel_gradient_magnitude] OK");
      else
         $display("[rgb_max_channel_gradient_magnitude] ERROR");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2000000;
      $display("timeout with %0d pixels queued and %0d beats outstanding",
               pixel_q.size(), grad_expect_q.size());
      $display("[rgb_max_channel_gradient_magnitude] ERROR");
      $finish;
   end

endmodule
